[sv/smwr_pkg.sv]
// Package: shared types, codes and sizes for the SPI master with registers.
`timescale 1ns / 1ps
package smwr_pkg;

  localparam int DATA_BITS     = 8;
  localparam int DIVIDER_BITS  = 8;
  localparam int BYTE_BITS     = 8;
  localparam int CMD_BITS      = 2;
  localparam int REG_BITS      = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int EDGE_BITS     = $clog2(2 * DATA_BITS + 1);
  localparam logic [EDGE_BITS-1:0] EDGE_LAST = EDGE_BITS'(2 * DATA_BITS - 1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [REG_BITS-1:0] {
    REG_CONTROL  = 2'd0,
    REG_STATUS   = 2'd1,
    REG_TRANSMIT = 2'd2,
    REG_RECEIVE  = 2'd3
  } reg_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DIVIDER  = 2'd0,
    CFG_POLARITY = 2'd1,
    CFG_PHASE    = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]  cmd;
    logic [REG_BITS-1:0]  reg_index;
    logic [BYTE_BITS-1:0] write_data;
    logic                 miso_in;
  } req_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] read_data;
    logic                 sclk_out;
    logic                 mosi_out;
    logic                 cs_out;
    logic                 busy_res;
  } rsp_t;

  typedef struct packed {
    logic [DIVIDER_BITS-1:0] divider;
    logic                    polarity;
    logic                    phase;
  } cfg_t;

  typedef struct packed {
    logic                    busy;
    logic                    rx_valid;
    logic [EDGE_BITS-1:0]    edge_count;
    logic [DIVIDER_BITS-1:0] tick_count;
  } status_t;

endpackage

[sv/smwr_cfg_if.sv]
// Interface: configuration write channel.
`timescale 1ns / 1ps
interface smwr_cfg_if;
  import smwr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [BYTE_BITS-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/smwr_req_if.sv]
// Interface: request channel (tick, register write, register read).
`timescale 1ns / 1ps
interface smwr_req_if;
  import smwr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  cmd;
  logic [REG_BITS-1:0]  reg_index;
  logic [BYTE_BITS-1:0] write_data;
  logic                 miso_in;
  modport source (output valid, cmd, reg_index, write_data, miso_in, input ready);
  modport sink (input valid, cmd, reg_index, write_data, miso_in, output ready);
endinterface

[sv/smwr_rsp_if.sv]
// Interface: result channel (read data and line levels).
`timescale 1ns / 1ps
interface smwr_rsp_if;
  import smwr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] read_data;
  logic                 sclk_out;
  logic                 mosi_out;
  logic                 cs_out;
  logic                 busy_res;
  modport source (output valid, read_data, sclk_out, mosi_out, cs_out, busy_res,
                  input ready);
  modport sink (input valid, read_data, sclk_out, mosi_out, cs_out, busy_res,
                output ready);
endinterface

[sv/spi_master_with_registers_top.sv]
// Top level: config registers, request register, SPI engine, result register.
// Requests wait in the request register, results in the result register.
// Throughput: one request per cycle; the request and result registers decouple
// the two channels, so a stalled result stops intake only when both are full.
// Reset (rst, synchronous): chip select high, idle, rx-valid clear, config zero,
// both pipeline registers empty.
`timescale 1ns / 1ps
module spi_master_with_registers_top (
  input  logic        clk,
  input  logic        rst,
  smwr_cfg_if.sink    cfg,
  smwr_req_if.sink    req,
  smwr_rsp_if.source  rsp
);
  import smwr_pkg::*;

  cfg_t    cfg_regs;
  logic    req_valid;
  req_t    req_reg;
  logic    rsp_valid;
  rsp_t    rsp_reg;
  rsp_t    core_rsp;
  status_t status;
  logic    step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_DIVIDER:  cfg_regs.divider  <= DIVIDER_BITS'(cfg.data);
        CFG_POLARITY: cfg_regs.polarity <= cfg.data[0];
        CFG_PHASE:    cfg_regs.phase    <= cfg.data[0];
        CFG_UNUSED: ;
      endcase
    end
  end

  assign step      = req_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !req_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_reg <= '{cmd: req.cmd, reg_index: req.reg_index,
                   write_data: req.write_data, miso_in: req.miso_in};
    end
  end

  smwr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .req    (req_reg),
    .cfg    (cfg_regs),
    .rsp    (core_rsp),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_reg <= core_rsp;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_reg.read_data;
  assign rsp.sclk_out  = rsp_reg.sclk_out;
  assign rsp.mosi_out  = rsp_reg.mosi_out;
  assign rsp.cs_out    = rsp_reg.cs_out;
  assign rsp.busy_res  = rsp_reg.busy_res;

  // idle engine always sits with counters cleared
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    !status.busy |-> (status.edge_count == '0) && (status.tick_count == '0))
    else $error("idle engine with nonzero counters");

  // a finished transfer leaves a received word flagged
  a_done_rx_valid: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(status.busy) |-> status.rx_valid)
    else $error("transfer ended without rx-valid");

  // every processed request shows up as a result next cycle
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> rsp.valid)
    else $error("processed request produced no result");

  // a request held in the input register is kept until processed
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !step |=> req_valid)
    else $error("pending request lost");

endmodule

[sv/smwr_core.sv]
// SPI engine: register file, divider, shifter and per-request result logic.
`timescale 1ns / 1ps
module smwr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  smwr_pkg::req_t   req,
  input  smwr_pkg::cfg_t   cfg,
  output smwr_pkg::rsp_t   rsp,
  output smwr_pkg::status_t status
);
  import smwr_pkg::*;

  logic                    cs_bit, cs_bit_next;
  logic                    busy, busy_next;
  logic                    rx_valid, rx_valid_next;
  logic [DATA_BITS-1:0]    shift_reg, shift_reg_next;
  logic [DATA_BITS-1:0]    rx_byte, rx_byte_next;
  logic [DIVIDER_BITS-1:0] tick_count, tick_count_next;
  logic [EDGE_BITS-1:0]    edge_count, edge_count_next;
  logic                    sclk_level, sclk_level_next;
  logic                    sample_bit, sample_bit_next;
  logic [BYTE_BITS-1:0]    read_data;
  logic                    leading;
  cmd_t                    cmd;
  reg_t                    reg_sel;

  assign cmd     = cmd_t'(req.cmd);
  assign reg_sel = reg_t'(req.reg_index);
  assign leading = ~edge_count[0];

  always_comb begin
    cs_bit_next     = cs_bit;
    busy_next       = busy;
    rx_valid_next   = rx_valid;
    shift_reg_next  = shift_reg;
    rx_byte_next    = rx_byte;
    tick_count_next = tick_count;
    edge_count_next = edge_count;
    sclk_level_next = sclk_level;
    sample_bit_next = sample_bit;
    read_data       = '0;
    unique case (cmd)
      CMD_TICK: begin
        if (busy) begin
          if (tick_count < cfg.divider) begin
            tick_count_next = tick_count + DIVIDER_BITS'(1);
          end else begin
            tick_count_next = '0;
            sclk_level_next = ~sclk_level;
            if (!cfg.phase) begin
              if (leading) begin
                sample_bit_next = req.miso_in;
              end else begin
                shift_reg_next = {shift_reg[DATA_BITS-2:0], sample_bit};
              end
            end else if (!leading) begin
              shift_reg_next = {shift_reg[DATA_BITS-2:0], req.miso_in};
            end
            if (edge_count == EDGE_LAST) begin
              rx_byte_next    = shift_reg_next;
              rx_valid_next   = 1'b1;
              busy_next       = 1'b0;
              edge_count_next = '0;
            end else begin
              edge_count_next = edge_count + EDGE_BITS'(1);
            end
          end
        end
      end
      CMD_WRITE: begin
        unique case (reg_sel)
          REG_CONTROL: cs_bit_next = req.write_data[0];
          REG_TRANSMIT: begin
            if (!busy) begin
              shift_reg_next  = DATA_BITS'(req.write_data);
              busy_next       = 1'b1;
              tick_count_next = '0;
              edge_count_next = '0;
              sample_bit_next = 1'b0;
              sclk_level_next = cfg.polarity;
            end
          end
          REG_STATUS, REG_RECEIVE: ;
        endcase
      end
      CMD_READ: begin
        unique case (reg_sel)
          REG_CONTROL: read_data = BYTE_BITS'(cs_bit);
          REG_STATUS:  read_data = BYTE_BITS'({rx_valid, busy});
          REG_RECEIVE: begin
            read_data     = BYTE_BITS'(rx_byte);
            rx_valid_next = 1'b0;
          end
          REG_TRANSMIT: ;
        endcase
      end
      CMD_NONE: ;
    endcase
  end

  always_comb begin
    rsp.read_data = read_data;
    rsp.sclk_out  = busy_next ? sclk_level_next : cfg.polarity;
    rsp.mosi_out  = busy_next & shift_reg_next[DATA_BITS-1];
    rsp.cs_out    = cs_bit_next;
    rsp.busy_res  = busy_next;
  end

  assign status = '{busy: busy, rx_valid: rx_valid, edge_count: edge_count,
                    tick_count: tick_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      cs_bit     <= 1'b1;
      busy       <= 1'b0;
      rx_valid   <= 1'b0;
      shift_reg  <= '0;
      rx_byte    <= '0;
      tick_count <= '0;
      edge_count <= '0;
      sclk_level <= 1'b0;
      sample_bit <= 1'b0;
    end else if (step) begin
      cs_bit     <= cs_bit_next;
      busy       <= busy_next;
      rx_valid   <= rx_valid_next;
      shift_reg  <= shift_reg_next;
      rx_byte    <= rx_byte_next;
      tick_count <= tick_count_next;
      edge_count <= edge_count_next;
      sclk_level <= sclk_level_next;
      sample_bit <= sample_bit_next;
    end
  end

endmodule
